// ===== hdl/gcaa_pkg.sv =====
// ----------------------------------------------------------------------------
// Gravity-compensated aim angles: shared package
// Widths, constants, the CORDIC angle table and the position record.
// ----------------------------------------------------------------------------
package gcaa_pkg;

  localparam int unsigned PosW   = 24;
  localparam int unsigned AngW   = 19;
  localparam int unsigned SpeedW = 16;
  localparam int unsigned QuotW  = 25;
  localparam int unsigned NumW   = 60;
  localparam int unsigned DenW   = 39;
  localparam int unsigned WideW  = 64;
  localparam int unsigned CordW  = 35;
  localparam int unsigned PhaseW = 32;

  localparam logic [SpeedW-1:0] SpeedReset = 16'd4352;
  localparam logic [SpeedW-1:0] SpeedMin   = 16'd3;

  localparam logic signed [PhaseW-1:0] HalfTurn = 32'sd188743680;
  localparam logic signed [PhaseW-1:0] AngLimit = 32'sd184320;
  localparam logic signed [PhaseW-1:0] RoundHalf = 32'sd512;

  localparam logic [26:0] AtanTab [32] = '{
    27'd47185920, 27'd27855475, 27'd14718068, 27'd7471121, 27'd3750058,
    27'd1876857, 27'd938658, 27'd469357, 27'd234682, 27'd117342, 27'd58671,
    27'd29335, 27'd14668, 27'd7334, 27'd3667, 27'd1833, 27'd917, 27'd458,
    27'd229, 27'd115, 27'd57, 27'd29, 27'd14, 27'd7, 27'd4, 27'd2, 27'd1,
    27'd0, 27'd0, 27'd0, 27'd0, 27'd0
  };

  typedef struct packed {
    logic signed [PosW-1:0] x;
    logic signed [PosW-1:0] y;
    logic signed [PosW-1:0] z;
  } pos_t;

endpackage

// ===== hdl/gravity_compensated_aim_angles.sv =====
// ----------------------------------------------------------------------------
// Gravity-compensated aim angles
// A new request is taken every cycle and busy never rises, since the
// receiver cannot stall. The depth is set by the 25-stage drop divider and
// the CORDIC stages.
// Reset clears all valid bits and loads the projectile speed with 17 m/s.
// ----------------------------------------------------------------------------
module gravity_compensated_aim_angles #(
  parameter int unsigned CORDIC_STAGES = 20
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [23:0] pos_x_i,
  input  logic signed [23:0] pos_y_i,
  input  logic signed [23:0] pos_z_i,
  input  logic               proj_speed_we_i,
  input  logic [15:0]        proj_speed_i,
  output logic               done_o,
  output logic signed [18:0] yaw_angle_o,
  output logic signed [18:0] pitch_angle_o
);
  import gcaa_pkg::*;

  logic [SpeedW-1:0] speed_q, speed_d;
  pos_t              pos_in, pos_corr;
  logic              accept, corr_valid, yaw_valid, pitch_valid;

  assign busy = 1'b0;
  assign accept = start && !busy;
  assign pos_in = '{x: pos_x_i, y: pos_y_i, z: pos_z_i};
  assign speed_d = proj_speed_we_i ? proj_speed_i : speed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q <= SpeedReset;
    end else begin
      speed_q <= speed_d;
    end
  end

  gcaa_drop u_drop (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .speed_i (speed_q),
    .valid_i (accept),
    .pos_i   (pos_in),
    .valid_o (corr_valid),
    .pos_o   (pos_corr)
  );

  gcaa_cordic #(.Stages(CORDIC_STAGES)) u_yaw (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (corr_valid),
    .num_i   (pos_corr.x),
    .den_i   (pos_corr.z),
    .valid_o (yaw_valid),
    .angle_o (yaw_angle_o)
  );

  gcaa_cordic #(.Stages(CORDIC_STAGES)) u_pitch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (corr_valid),
    .num_i   (pos_corr.y),
    .den_i   (pos_corr.z),
    .valid_o (pitch_valid),
    .angle_o (pitch_angle_o)
  );

  assign done_o = yaw_valid && pitch_valid;

endmodule

// ===== hdl/gcaa_drop.sv =====
// ----------------------------------------------------------------------------
// Gravity drop correction
// Squares distance and speed, divides in a one-bit-per-stage restoring divider
// and subtracts the rounded drop from y with saturation (no drop below SpeedMin).
// ----------------------------------------------------------------------------
module gcaa_drop (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [15:0]            speed_i,
  input  logic                   valid_i,
  input  gcaa_pkg::pos_t         pos_i,
  output logic                   valid_o,
  output gcaa_pkg::pos_t         pos_o
);
  import gcaa_pkg::*;

  logic [PosW-1:0]     az;
  logic                v1_q, v2_q, v3_q;
  pos_t                p1_q, p2_q, p3_q;
  logic [2*PosW-1:0]   sq1_q;
  logic [31:0]         ss1_q;
  logic                slow1_q, slow2_q, slow3_q;
  logic [NumW-1:0]     num2_q, n3_q;
  logic [DenW-1:0]     den2_q, den3_q;
  logic [52:0]         sq49;

  logic                val_q  [QuotW+1];
  pos_t                pos_q  [QuotW+1];
  logic                slow_q [QuotW+1];
  logic                ovf_q  [QuotW+1];
  logic [NumW-1:0]     rem_q  [QuotW+1];
  logic [DenW-1:0]     den_q  [QuotW+1];
  logic [QuotW-1:0]    quo_q  [QuotW+1];

  logic signed [26:0]  diff;
  logic signed [PosW-1:0] yc;
  logic                vo_q;
  pos_t                po_q;

  assign az   = pos_i.z[PosW-1] ? (~pos_i.z + 1'b1) : pos_i.z;
  assign sq49 = ({5'b0, sq1_q} << 5) + ({5'b0, sq1_q} << 4) + {5'b0, sq1_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      val_q[0]  <= 1'b0;
    end else begin
      v1_q      <= valid_i;
      v2_q      <= v1_q;
      v3_q      <= v2_q;
      val_q[0]  <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_q      <= pos_i;
    sq1_q     <= az * az;
    ss1_q     <= speed_i * speed_i;
    slow1_q   <= speed_i < SpeedMin;
    p2_q      <= p1_q;
    slow2_q   <= slow1_q;
    num2_q    <= {sq49, 7'b0};
    den2_q    <= ({7'b0, ss1_q} << 7) - ({7'b0, ss1_q} << 1) - {7'b0, ss1_q};
    p3_q      <= p2_q;
    slow3_q   <= slow2_q;
    n3_q      <= num2_q + NumW'(den2_q >> 1);
    den3_q    <= den2_q;
    pos_q[0]  <= p3_q;
    slow_q[0] <= slow3_q;
    ovf_q[0]  <= {4'b0, n3_q} >= {den3_q, 25'b0};
    rem_q[0]  <= n3_q;
    den_q[0]  <= den3_q;
    quo_q[0]  <= '0;
  end

  for (genvar s = 0; s < QuotW; s++) begin : g_div
    localparam int unsigned J = QuotW - 1 - s;
    logic [WideW-1:0] dsh;
    logic             ge;
    assign dsh = {25'b0, den_q[s]} << J;
    assign ge  = {4'b0, rem_q[s]} >= dsh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        val_q[s+1] <= 1'b0;
      end else begin
        val_q[s+1] <= val_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      pos_q[s+1]  <= pos_q[s];
      slow_q[s+1] <= slow_q[s];
      ovf_q[s+1]  <= ovf_q[s];
      den_q[s+1]  <= den_q[s];
      if (ge) begin
        rem_q[s+1] <= rem_q[s] - NumW'(dsh);
        quo_q[s+1] <= quo_q[s] | (QuotW'(1) << J);
      end else begin
        rem_q[s+1] <= rem_q[s];
        quo_q[s+1] <= quo_q[s];
      end
    end
  end

  assign diff = {{3{pos_q[QuotW].y[PosW-1]}}, pos_q[QuotW].y} - {2'b0, quo_q[QuotW]};

  always_comb begin
    if (slow_q[QuotW]) begin
      yc = pos_q[QuotW].y;
    end else if (ovf_q[QuotW] || (diff[26:23] != {4{diff[26]}})) begin
      yc = {1'b1, {(PosW-1){1'b0}}};
    end else begin
      yc = diff[PosW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else begin
      vo_q <= val_q[QuotW];
    end
  end

  always_ff @(posedge clk_i) begin
    po_q.x <= pos_q[QuotW].x;
    po_q.y <= yc;
    po_q.z <= pos_q[QuotW].z;
  end

  assign valid_o = vo_q;
  assign pos_o   = po_q;

endmodule

// ===== hdl/gcaa_cordic.sv =====
// ----------------------------------------------------------------------------
// Vectoring CORDIC atan2
// Quadrant pre-rotation, one micro-rotation per stage, then rounding to
// 1/1024 degree with clamping.
// ----------------------------------------------------------------------------
module gcaa_cordic #(
  parameter int unsigned Stages = 20
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic signed [23:0]        num_i,
  input  logic signed [23:0]        den_i,
  output logic                      valid_o,
  output logic signed [18:0]        angle_o
);
  import gcaa_pkg::*;

  logic signed [CordW-1:0]  x_q [Stages+1];
  logic signed [CordW-1:0]  y_q [Stages+1];
  logic signed [PhaseW-1:0] a_q [Stages+1];
  logic                     zero_q  [Stages+1];
  logic                     valid_q [Stages+1];

  logic signed [CordW-1:0]  num_e, den_e;
  logic signed [PhaseW-1:0] rnd;
  logic signed [AngW-1:0]   ang_d;
  logic signed [AngW-1:0]   ang_q;
  logic                     vo_q;

  assign num_e = CordW'(num_i);
  assign den_e = CordW'(den_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else begin
      valid_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    zero_q[0] <= (num_i == '0) && (den_i == '0);
    if (den_i[23]) begin
      x_q[0] <= (-den_e) <<< 8;
      y_q[0] <= (-num_e) <<< 8;
      a_q[0] <= num_i[23] ? -HalfTurn : HalfTurn;
    end else begin
      x_q[0] <= den_e <<< 8;
      y_q[0] <= num_e <<< 8;
      a_q[0] <= '0;
    end
  end

  for (genvar i = 0; i < Stages; i++) begin : g_stage
    localparam int unsigned K = i % 32;
    logic signed [CordW-1:0]  xs, ys;
    logic signed [PhaseW-1:0] at;
    assign xs = x_q[i] >>> K;
    assign ys = y_q[i] >>> K;
    assign at = {5'b0, AtanTab[K]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i+1] <= 1'b0;
      end else begin
        valid_q[i+1] <= valid_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      zero_q[i+1] <= zero_q[i];
      if (!y_q[i][CordW-1]) begin
        x_q[i+1] <= x_q[i] + ys;
        y_q[i+1] <= y_q[i] - xs;
        a_q[i+1] <= a_q[i] + at;
      end else begin
        x_q[i+1] <= x_q[i] - ys;
        y_q[i+1] <= y_q[i] + xs;
        a_q[i+1] <= a_q[i] - at;
      end
    end
  end

  assign rnd = (a_q[Stages] + RoundHalf) >>> 10;

  always_comb begin
    if (zero_q[Stages]) begin
      ang_d = '0;
    end else if (rnd > AngLimit) begin
      ang_d = AngW'(AngLimit);
    end else if (rnd < -AngLimit) begin
      ang_d = AngW'(-AngLimit);
    end else begin
      ang_d = rnd[AngW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else begin
      vo_q <= valid_q[Stages];
    end
  end

  always_ff @(posedge clk_i) begin
    ang_q <= ang_d;
  end

  assign valid_o = vo_q;
  assign angle_o = ang_q;

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// Gravity-compensated aim angles: testbench
// Feeds target positions through a randomized driver, with speed register
// writes between phases, and checks each aim-angle pair against a predictor.
// ----------------------------------------------------------------------------
module testbench;

  import gcaa_pkg::*;

  localparam int unsigned Stages = 20;
  localparam int unsigned Latency = 32 + Stages;
  localparam int unsigned CycleLimit = 400000;

  typedef enum {REQ_POS, REQ_SPEED, REQ_DRAIN} req_kind_e;

  typedef struct {
    req_kind_e kind;
    logic [PosW-1:0] x;
    logic [PosW-1:0] y;
    logic [PosW-1:0] z;
    logic [SpeedW-1:0] speed;
    int gap;
  } request_t;

  typedef struct {
    logic signed [AngW-1:0] yaw;
    logic signed [AngW-1:0] pitch;
  } aim_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic [PosW-1:0] pos_x_i = '0;
  logic [PosW-1:0] pos_y_i = '0;
  logic [PosW-1:0] pos_z_i = '0;
  logic proj_speed_we_i = 1'b0;
  logic [SpeedW-1:0] proj_speed_i = '0;
  logic busy;
  logic done_o;
  logic signed [AngW-1:0] yaw_angle_o;
  logic signed [AngW-1:0] pitch_angle_o;

  request_t pending_q[$];
  aim_t expected_aim_q[$];
  logic [SpeedW-1:0] speed_model = SpeedReset;
  int gap_left = 0;
  bit driver_idle = 1'b0;
  int errors = 0;
  int cycles = 0;
  bit zero_gaps = 1'b0;
  logic [SpeedW-1:0] spd_list[4] = '{16'd0, 16'd2, 16'd3, 16'hFFFF};

  gravity_compensated_aim_angles #(.CORDIC_STAGES(Stages)) u_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .pos_x_i(pos_x_i),
    .pos_y_i(pos_y_i),
    .pos_z_i(pos_z_i),
    .proj_speed_we_i(proj_speed_we_i),
    .proj_speed_i(proj_speed_i),
    .done_o(done_o),
    .yaw_angle_o(yaw_angle_o),
    .pitch_angle_o(pitch_angle_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic logic signed [AngW-1:0] cordic_angle(longint num, longint den);
    longint xx, yy, ang, nx, ny, tab, r;
    int k;
    if (num == 0 && den == 0) begin
      return '0;
    end
    xx = den;
    yy = num;
    ang = 0;
    if (den < 0) begin
      xx = -den;
      yy = -num;
      ang = (num >= 0) ? longint'(HalfTurn) : -longint'(HalfTurn);
    end
    xx = xx * 256;
    yy = yy * 256;
    for (int i = 0; i < Stages; i++) begin
      k = i % 32;
      tab = longint'(AtanTab[k]);
      if (yy >= 0) begin
        nx = xx + (yy >>> k);
        ny = yy - (xx >>> k);
        ang = ang + tab;
      end else begin
        nx = xx - (yy >>> k);
        ny = yy + (xx >>> k);
        ang = ang - tab;
      end
      xx = nx;
      yy = ny;
    end
    r = (ang + 512) >>> 10;
    if (r > 184320) r = 184320;
    if (r < -184320) r = -184320;
    return r[AngW-1:0];
  endfunction

  function automatic aim_t predict_aim(logic [PosW-1:0] px, logic [PosW-1:0] py,
                                       logic [PosW-1:0] pz, logic [SpeedW-1:0] spd);
    longint x, y, z, yc;
    longint unsigned az, nm, dn, drop;
    aim_t res;
    x = longint'(signed'(px));
    y = longint'(signed'(py));
    z = longint'(signed'(pz));
    drop = 0;
    if (spd >= SpeedMin) begin
      az = (z < 0) ? -z : z;
      nm = 64'd6272 * az * az;
      dn = 64'd125 * spd * spd;
      drop = (nm + dn / 2) / dn;
    end
    yc = y - longint'(drop);
    if (yc > 8388607) yc = 8388607;
    if (yc < -8388608) yc = -8388608;
    res.yaw = cordic_angle(x, z);
    res.pitch = cordic_angle(yc, z);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    request_t head;
    logic start_nxt, we_nxt;
    if (!rst_ni) begin
      start <= 1'b0;
      proj_speed_we_i <= 1'b0;
    end else begin
      start_nxt = 1'b0;
      we_nxt = 1'b0;
      if (start && !busy) begin
        expected_aim_q.insert(expected_aim_q.size(),
                              predict_aim(pos_x_i, pos_y_i, pos_z_i, speed_model));
      end
      if (start && busy) begin
        start_nxt = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (pending_q.size() == 0) begin
        driver_idle = 1'b1;
      end else begin
        head = pending_q[0];
        case (head.kind)
          REQ_POS: begin
            start_nxt = 1'b1;
            pos_x_i <= head.x;
            pos_y_i <= head.y;
            pos_z_i <= head.z;
            gap_left = head.gap;
            void'(pending_q.pop_front());
          end
          REQ_SPEED: begin
            if (expected_aim_q.size() == 0) begin
              we_nxt = 1'b1;
              proj_speed_i <= head.speed;
              speed_model = head.speed;
              void'(pending_q.pop_front());
            end
          end
          default: begin
            if (expected_aim_q.size() == 0) begin
              gap_left = head.gap;
              void'(pending_q.pop_front());
            end
          end
        endcase
      end
      start <= start_nxt;
      proj_speed_we_i <= we_nxt;
    end
  end

  always @(posedge clk_i) begin
    aim_t exp_aim;
    if (rst_ni && done_o) begin
      if (expected_aim_q.size() == 0) begin
        $display("%0t: unexpected result yaw %0d pitch %0d", $time, yaw_angle_o,
                 pitch_angle_o);
        errors++;
      end else begin
        exp_aim = expected_aim_q.pop_front();
        if (yaw_angle_o !== exp_aim.yaw) begin
          $display("%0t: yaw expected %0d actual %0d", $time, exp_aim.yaw, yaw_angle_o);
          errors++;
        end
        if (pitch_angle_o !== exp_aim.pitch) begin
          $display("%0t: pitch expected %0d actual %0d", $time, exp_aim.pitch,
                   pitch_angle_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int draw_gap();
    return zero_gaps ? 0 : $urandom_range(0, 12);
  endfunction

  task automatic add_pos(logic [PosW-1:0] x, logic [PosW-1:0] y, logic [PosW-1:0] z);
    request_t r;
    r.kind = REQ_POS;
    r.x = x;
    r.y = y;
    r.z = z;
    r.speed = '0;
    r.gap = draw_gap();
    pending_q.insert(pending_q.size(), r);
  endtask

  task automatic add_speed(logic [SpeedW-1:0] spd);
    request_t r;
    r = '{kind: REQ_SPEED, x: '0, y: '0, z: '0, speed: spd, gap: 0};
    pending_q.insert(pending_q.size(), r);
  endtask

  function automatic logic [PosW-1:0] draw_coord(bit forward);
    case ($urandom_range(0, 5))
      0: return PosW'($urandom());
      1: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
      2: return PosW'($urandom_range(0, 3) - 2);
      default: begin
        if (forward) return PosW'($urandom_range(3200, 1280000));
        return 24'(int'($urandom_range(0, 400000)) - 200000);
      end
    endcase
  endfunction

  initial begin
    logic [SpeedW-1:0] spd;
    request_t drain;
    add_pos(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    add_pos(24'h800000, 24'h800000, 24'h800000);
    add_pos(24'h000000, 24'h000000, 24'h000000);
    add_pos(24'h000000, 24'h000100, 24'hFFFF00);
    add_pos(24'h000000, 24'hFFFF00, 24'hFFFF00);
    add_pos(24'h000040, 24'h000000, 24'h000000);
    add_pos(24'hFFFFC0, 24'h000000, 24'h000000);
    add_pos(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    add_pos(24'h001000, 24'h7FFFFF, 24'h800000);
    add_pos(24'h000640, 24'h000C80, 24'h00FA00);
    add_pos(24'h555555, 24'hAAAAAA, 24'h555555);
    add_pos(24'hAAAAAA, 24'h555555, 24'hAAAAAA);
    drain = '{kind: REQ_DRAIN, x: '0, y: '0, z: '0, speed: '0, gap: 20};
    pending_q.insert(pending_q.size(), drain);
    add_pos(24'h000000, 24'h800000, 24'h7FFFFF);
    foreach (spd_list[i]) begin
      add_speed(spd_list[i]);
      add_pos(24'h000000, 24'h800000, 24'h7FFFFF);
      add_pos(24'h010000, 24'h000000, 24'h800000);
      add_pos(24'h000800, 24'h001000, 24'h0A0000);
    end
    for (int phase = 0; phase < 12; phase++) begin
      zero_gaps = (phase % 4 == 1);
      case (phase % 6)
        0: spd = '0;
        1: spd = 16'hFFFF;
        2: spd = SpeedMin;
        3: spd = 16'd2;
        default: spd = $urandom_range(0, 1) ? SpeedW'($urandom())
                                            : SpeedW'($urandom_range(1280, 8000));
      endcase
      add_speed(spd);
      for (int n = 0; n < 95; n++) begin
        add_pos(draw_coord(1'b0), draw_coord(1'b0), draw_coord(1'b1));
      end
    end
    add_speed(SpeedReset);
    for (int n = 0; n < 10; n++) begin
      add_pos(PosW'($urandom()), PosW'($urandom()), PosW'($urandom()));
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (driver_idle && pending_q.size() == 0 && expected_aim_q.size() == 0);
    repeat (Latency + 20) @(posedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
